@@ hdl/rmrpy_pkg.sv @@
// Shared constants and helpers for the rotation-matrix to roll/pitch/yaw unit.
// Holds the CORDIC stage angle table and fixed-point reduction functions.
// No dependencies.
package rmrpy_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;

    // atan(2^-i) in Q2.30
    localparam logic signed [63:0] ATAN_Q30 [0:31] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128,
        64'sd64,        64'sd32,        64'sd16,        64'sd8,
        64'sd4,         64'sd2,         64'sd1,         64'sd0
    };

    // Reduce a Q2.30 angle to frac fraction bits, rounding half up.
    function automatic logic signed [63:0] q30_to_frac(input logic signed [63:0] a,
                                                       input int frac);
        int s;
        s = 30 - frac;
        if (s == 0) begin
            return a;
        end
        return (a + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] stage_angle(input int stage, input int frac);
        return q30_to_frac(ATAN_Q30[stage], frac);
    endfunction

endpackage

@@ hdl/rotation_matrix_to_rpy_unit.sv @@
// Rotation matrix to roll/pitch/yaw: fully pipelined, one request per cycle.
// Registers in order: input clamp, radicand square,
// FRAC_BITS+1 square-root digit cells, quadrant pre-rotation, CORDIC_STAGES
// micro-rotation cells (three lanes side by side) and the output register.
// A new request is taken every cycle unless the output is stalled with a
// result waiting; the whole pipeline then holds.
module rotation_matrix_to_rpy_unit
    import rmrpy_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [FRAC_BITS+1:0] i_r00,
    input  logic signed [FRAC_BITS+1:0] i_r10,
    input  logic signed [FRAC_BITS+1:0] i_r20,
    input  logic signed [FRAC_BITS+1:0] i_r21,
    input  logic signed [FRAC_BITS+1:0] i_r22,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [FRAC_BITS+2:0] o_roll,
    output logic signed [FRAC_BITS+1:0] o_pitch,
    output logic signed [FRAC_BITS+2:0] o_yaw,
    output logic                     o_gimbal_lock
);

    localparam int IW     = FRAC_BITS + 2;
    localparam int W      = FRAC_BITS + 4;
    localparam int NW     = 2 * FRAC_BITS + 2;
    localparam int RTW    = FRAC_BITS + 1;
    localparam int SQ_N   = FRAC_BITS + 1;
    localparam int SIDE_W = 5 * IW + 1;

    localparam logic signed [63:0] HP64 = q30_to_frac(Q30_HALF_PI, FRAC_BITS);
    localparam logic signed [W-1:0] HP  = HP64[W-1:0];
    localparam logic signed [W-1:0] PI  = HP64[W-2:0] <<< 1;
    localparam logic signed [IW-1:0] ONE = IW'(1) <<< FRAC_BITS;
    localparam logic [NW-1:0] ONE_SQ = NW'(1) <<< (2 * FRAC_BITS);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    function automatic logic signed [IW-1:0] clamp_in(input logic signed [IW-1:0] v);
        if (v > ONE) begin
            return ONE;
        end else if (v < -ONE) begin
            return -ONE;
        end
        return v;
    endfunction

    // stage A: clamp
    logic                 r_a_valid;
    logic signed [IW-1:0] r_a00, r_a10, r_a20, r_a21, r_a22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a00 <= clamp_in(i_r00);
            r_a10 <= clamp_in(i_r10);
            r_a20 <= clamp_in(i_r20);
            r_a21 <= clamp_in(i_r21);
            r_a22 <= clamp_in(i_r22);
        end
    end

    // stage B: radicand ONE^2 - r20^2, lock flag
    logic                 r_b_valid;
    logic [NW-1:0]        r_b_n;
    logic [SIDE_W-1:0]    r_b_side;
    logic signed [2*IW-1:0] sq20;
    logic                 lock_a;

    assign sq20   = r_a20 * r_a20;
    assign lock_a = (r_a20 >= ONE) || (r_a20 <= -ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_n    <= ONE_SQ - sq20[NW-1:0];
            r_b_side <= {lock_a, r_a00, r_a10, r_a20, r_a21, r_a22};
        end
    end

    // square-root digit chain
    logic              sq_valid [0:SQ_N];
    logic [NW-1:0]     sq_n     [0:SQ_N];
    logic [RTW+1:0]    sq_rem   [0:SQ_N];
    logic [RTW-1:0]    sq_root  [0:SQ_N];
    logic [SIDE_W-1:0] sq_side  [0:SQ_N];

    assign sq_valid[0] = r_b_valid;
    assign sq_n[0]     = r_b_n;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = r_b_side;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        rmrpy_sqrt_cell #(
            .NW     (NW),
            .RTW    (RTW),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_n     (sq_n[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_n     (sq_n[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // unpack side payload at the end of the root chain
    logic                 s_lock;
    logic signed [IW-1:0] s00, s10, s20, s21, s22;
    assign {s_lock, s00, s10, s20, s21, s22} = sq_side[SQ_N];

    // pre-rotation into the right half plane
    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
    } t_vec;

    function automatic t_vec prerot(input logic signed [W-1:0] y,
                                    input logic signed [W-1:0] x);
        t_vec v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HP;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HP;
            end
        end
        return v;
    endfunction

    localparam int NL = 3; // lanes: roll, yaw, pitch
    localparam int LR = 0;
    localparam int LY = 1;
    localparam int LP = 2;

    logic                c_valid [0:NL-1][0:CORDIC_STAGES];
    logic signed [W-1:0] c_x     [0:NL-1][0:CORDIC_STAGES];
    logic signed [W-1:0] c_y     [0:NL-1][0:CORDIC_STAGES];
    logic signed [W-1:0] c_z     [0:NL-1][0:CORDIC_STAGES];
    logic [1:0]          c_side  [0:NL-1][0:CORDIC_STAGES];

    logic                r_p_valid;
    t_vec                r_p_vec [0:NL-1];
    logic [1:0]          r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= sq_valid[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_vec[LR] <= prerot(W'(s21), W'(s22));
            r_p_vec[LY] <= prerot(W'(s10), W'(s00));
            r_p_vec[LP] <= prerot(W'(s20), W'(sq_root[SQ_N]));
            r_p_side    <= {s_lock, s20[IW-1]};
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        assign c_valid[l][0] = r_p_valid;
        assign c_x[l][0]     = r_p_vec[l].x;
        assign c_y[l][0]     = r_p_vec[l].y;
        assign c_z[l][0]     = r_p_vec[l].z;
        assign c_side[l][0]  = r_p_side;
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            rmrpy_cordic_cell #(
                .FRAC_BITS (FRAC_BITS),
                .STAGE     (s),
                .W         (W),
                .SIDE_W    (2)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (c_valid[l][s]),
                .i_x     (c_x[l][s]),
                .i_y     (c_y[l][s]),
                .i_z     (c_z[l][s]),
                .i_side  (c_side[l][s]),
                .o_valid (c_valid[l][s+1]),
                .o_x     (c_x[l][s+1]),
                .o_y     (c_y[l][s+1]),
                .o_z     (c_z[l][s+1]),
                .o_side  (c_side[l][s+1])
            );
        end
    end

    // final saturation and gimbal-lock selection
    logic signed [W-1:0] z_roll, z_yaw, z_pitch, nz_pitch;
    logic                f_lock, f_neg;

    function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v,
                                                input logic signed [W-1:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    assign {f_lock, f_neg} = c_side[LR][CORDIC_STAGES];
    assign z_roll   = sat(c_z[LR][CORDIC_STAGES], PI);
    assign z_yaw    = f_lock ? '0 : sat(c_z[LY][CORDIC_STAGES], PI);
    assign nz_pitch = -c_z[LP][CORDIC_STAGES];
    assign z_pitch  = f_lock ? (f_neg ? HP : -HP) : sat(nz_pitch, HP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= c_valid[LR][CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll        <= z_roll[FRAC_BITS+2:0];
            o_yaw         <= z_yaw[FRAC_BITS+2:0];
            o_pitch       <= z_pitch[FRAC_BITS+1:0];
            o_gimbal_lock <= f_lock;
        end
    end

endmodule

@@ hdl/rmrpy_sqrt_cell.sv @@
// One radix-2 digit cell of the pipelined integer square root.
// Takes two radicand bits, produces one root bit. Depends on nothing else.
module rmrpy_sqrt_cell #(
    parameter int NW     = 34,
    parameter int RTW    = 17,
    parameter int SIDE_W = 91
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_n,
    input  logic [RTW+1:0]    i_rem,
    input  logic [RTW-1:0]    i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NW-1:0]     o_n,
    output logic [RTW+1:0]    o_rem,
    output logic [RTW-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic [RTW+3:0] rem_t;
    logic [RTW+3:0] trial;
    logic           take;
    logic [RTW+3:0] rem_d;

    assign rem_t = {i_rem, i_n[NW-1 -: 2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign take  = (rem_t >= trial);
    assign rem_d = take ? (rem_t - trial) : rem_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n    <= {i_n[NW-3:0], 2'b00};
            o_rem  <= rem_d[RTW+1:0];
            o_root <= {i_root[RTW-2:0], take};
            o_side <= i_side;
        end
    end

endmodule

@@ hdl/rmrpy_cordic_cell.sv @@
// One vectoring-mode CORDIC micro-rotation cell.
// Uses rmrpy_pkg for the stage angle.
module rmrpy_cordic_cell
    import rmrpy_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int STAGE     = 0,
    parameter int W         = FRAC_BITS_DEF + 4,
    parameter int SIDE_W    = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z,
    output logic [SIDE_W-1:0]   o_side
);

    localparam logic signed [63:0] ANG64 = stage_angle(STAGE, FRAC_BITS);
    localparam logic signed [W-1:0] ANG  = ANG64[W-1:0];

    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // rotate y toward zero, accumulating the angle in z; zero residual: hold vector and angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (i_y > 0) begin
                o_x <= i_x + dx;
                o_y <= i_y - dy;
                o_z <= i_z + ANG;
            end else if (i_y < 0) begin
                o_x <= i_x - dx;
                o_y <= i_y + dy;
                o_z <= i_z - ANG;
            end else begin
                o_x <= i_x;
                o_y <= i_y;
                o_z <= i_z;
            end
        end
    end

endmodule

@@ hdl/rmrpy_checker.sv @@
// Port-level checks for rotation_matrix_to_rpy_unit, bound to the top level.
// Depends on rmrpy_pkg for the half-pi constant.
module rmrpy_checker
    import rmrpy_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic signed [FRAC_BITS+1:0] i_r00,
    input logic signed [FRAC_BITS+1:0] i_r10,
    input logic signed [FRAC_BITS+1:0] i_r20,
    input logic signed [FRAC_BITS+1:0] i_r21,
    input logic signed [FRAC_BITS+1:0] i_r22,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [FRAC_BITS+2:0] o_roll,
    input logic signed [FRAC_BITS+1:0] o_pitch,
    input logic signed [FRAC_BITS+2:0] o_yaw,
    input logic                        o_gimbal_lock
);

    localparam logic signed [63:0] HP64 = q30_to_frac(Q30_HALF_PI, FRAC_BITS);
    localparam logic signed [FRAC_BITS+1:0] HP = HP64[FRAC_BITS+1:0];

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_roll) && $stable(o_pitch)
                                  && $stable(o_yaw) && $stable(o_gimbal_lock)))
        else $error("stalled result changed");

    a_lock_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_lock) |-> (o_yaw == '0 && (o_pitch == HP || o_pitch == -HP)))
        else $error("gimbal lock result malformed");

endmodule

bind rotation_matrix_to_rpy_unit rmrpy_checker #(.FRAC_BITS(FRAC_BITS)) u_rmrpy_checker (.*);
